>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted (reset is active low).
`define SBFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define SBFD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBFD_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

>>> src/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared types and constants of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    localparam int CountWidthDef = 16;

    localparam int NumCh      = 16;
    localparam int ChIdxW     = 4;
    localparam int ChW        = 11;
    localparam int StoreBytes = 24;
    localparam int StoreW     = StoreBytes * 8;
    localparam int PosW       = 5;
    localparam int OutCntW    = 16;

    localparam logic [7:0] HdrByte = 8'h0F;
    localparam logic [7:0] FtrByte = 8'h00;
    localparam int LostBit = 2;
    localparam int FsBit   = 3;

    // Q16 gain and offset of the two scaling ranges
    localparam int GainW = 20;
    localparam int ProdW = ChW + GainW;
    localparam int SumW  = ProdW + 2;
    localparam int ScW   = 15;
    localparam logic [GainW-1:0]       GainNorm = GainW'(799257);
    localparam logic [GainW-1:0]       GainExt  = GainW'(960469);
    localparam logic signed [SumW-1:0] OfsNorm  = -SumW'(792863336);
    localparam logic signed [SumW-1:0] OfsExt   = -SumW'(982974464);
    localparam logic [SumW-1:0]        RndPos   = SumW'(32768);
    localparam logic [SumW-1:0]        RndNeg   = SumW'(32767);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_OFS,
        S_RND,
        S_ERR
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic ofs_en;
        logic ext;
    } t_scale_ctl;

endpackage

>>> src/sbfd_scale.sv
// ----------------------------------------------------------------------------
// sbfd_scale
// Shared scaling unit: multiply by Q16 gain, add offset, round half away
// from zero. One step per enable; the rounded result is combinational.
// ----------------------------------------------------------------------------
module sbfd_scale
    import sbfd_pkg::*;
(
    input  logic                  i_clk,
    input  t_scale_ctl            i_ctl,
    input  logic [ChW-1:0]        i_raw,
    output logic signed [ScW-1:0] o_scaled
);

    logic [ProdW-1:0]       r_prod;
    logic signed [SumW-1:0] r_sum;
    logic [GainW-1:0]       w_gain;
    logic signed [SumW-1:0] w_ofs;
    logic signed [SumW-1:0] w_rnd;

    assign w_gain = i_ctl.ext ? GainExt : GainNorm;
    assign w_ofs  = i_ctl.ext ? OfsExt  : OfsNorm;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= {{(ProdW-ChW){1'b0}}, i_raw} * {{(ProdW-GainW){1'b0}}, w_gain};
        end
        if (i_ctl.ofs_en) begin
            r_sum <= $signed({{(SumW-ProdW){1'b0}}, r_prod}) + w_ofs;
        end
    end

    // negative values: ceil((x - 32768) / 2^16) == (x + 32767) >>> 16
    assign w_rnd    = r_sum + $signed(r_sum[SumW-1] ? RndNeg : RndPos);
    assign o_scaled = w_rnd[16+ScW-1:16];

endmodule

>>> src/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder: bytes 1 to 24 of a frame are shifted into a byte store.
// The 25th byte of a good frame runs 16 channels through the shared multiply /
// offset / round unit, one channel at a time in S_MUL, S_OFS and S_RND;
// a bad frame gives a single error item from S_ERR. Input stalls during that.
// Synchronous active-low reset clears counters, previous values, position,
// range select and output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbus_frame_decoder
    import sbfd_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDef
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ChIdxW-1:0]     o_channel_index,
    output logic [ChW-1:0]        o_raw_value,
    output logic signed [ScW-1:0] o_scaled_value,
    output logic                  o_changed,
    output logic                  o_frame_error,
    output logic                  o_failsafe,
    output logic                  o_frame_lost,
    output logic [OutCntW-1:0]    o_lost_frame_count,
    output logic [OutCntW-1:0]    o_error_count,
    output logic                  o_last
);

    t_state                   r_state, n_state;
    logic                     r_ext;
    logic [PosW-1:0]          r_pos;
    logic [StoreW-1:0]        r_sr;
    logic [ChW-1:0]           r_prev [NumCh];
    logic [ChIdxW-1:0]        r_ch;
    logic                     r_fs, r_lost;
    logic [COUNT_WIDTH-1:0]   r_lost_cnt, r_err_cnt;

    logic                     w_take_in, w_out_free;
    logic [PosW-1:0]          w_pos;
    logic                     w_final, w_good;
    logic [ChW-1:0]           w_raw;
    logic                     w_last_ch;
    logic                     w_load_ch, w_load_err;
    t_scale_ctl               w_ctl;
    logic signed [ScW-1:0]    w_scaled;
    logic [COUNT_WIDTH+OutCntW-1:0] w_lost_ext, w_err_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_take_in  = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;

    // marked byte restarts the frame; an impossible position is taken as 0
    always_comb begin
        w_pos = i_frame_start ? '0 : r_pos;
        if (w_pos > PosW'(StoreBytes)) begin
            w_pos = '0;
        end
    end
    assign w_final = (w_pos == PosW'(StoreBytes));
    // after 24 bytes the store holds byte 0 in its low byte
    assign w_good  = (r_sr[7:0] == HdrByte) && (i_byte_value == FtrByte);

    // current channel sits at bits 8.. (byte 1 onward), shifted down per channel
    assign w_raw     = r_sr[8 +: ChW];
    assign w_last_ch = (r_ch == ChIdxW'(NumCh - 1));

    assign w_lost_ext = {{OutCntW{1'b0}}, r_lost_cnt};
    assign w_err_ext  = {{OutCntW{1'b0}}, r_err_cnt};

    sbfd_scale u_scale (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_raw    (w_raw),
        .o_scaled (w_scaled)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take_in && w_final) begin
                    n_state = w_good ? S_MUL : S_ERR;
                end
            end
            S_MUL:  n_state = S_OFS;
            S_OFS:  n_state = S_RND;
            S_RND: begin
                if (w_out_free) begin
                    n_state = w_last_ch ? S_IDLE : S_MUL;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ctl.mul_en = 1'b0;
        w_ctl.ofs_en = 1'b0;
        w_ctl.ext    = r_ext;
        w_load_ch    = 1'b0;
        w_load_err   = 1'b0;
        case (r_state)
            S_MUL:   w_ctl.mul_en = 1'b1;
            S_OFS:   w_ctl.ofs_en = 1'b1;
            S_RND:   w_load_ch    = w_out_free;
            S_ERR:   w_load_err   = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ext      <= 1'b0;
            r_pos      <= '0;
            r_ch       <= '0;
            r_lost_cnt <= '0;
            r_err_cnt  <= '0;
            for (int i = 0; i < NumCh; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ext <= i_cfg_wdata;
            end
            if (w_take_in) begin
                if (w_final) begin
                    r_pos <= '0;
                    r_ch  <= '0;
                    if (!w_good) begin
                        r_err_cnt <= r_err_cnt + 1'b1;
                    end else if (r_sr[StoreW-8+LostBit]) begin
                        r_lost_cnt <= r_lost_cnt + 1'b1;
                    end
                end else begin
                    r_pos <= w_pos + 1'b1;
                end
            end
            if (w_load_ch) begin
                r_ch <= r_ch + 1'b1;
                // rotate so the next channel's previous value is at the head
                for (int i = 0; i < NumCh - 1; i++) begin
                    r_prev[i] <= r_prev[i+1];
                end
                r_prev[NumCh-1] <= w_raw;
            end
        end
    end

    // frame bytes and flags: payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            if (w_final) begin
                r_fs   <= r_sr[StoreW-8+FsBit];
                r_lost <= r_sr[StoreW-8+LostBit];
            end else begin
                r_sr <= {i_byte_value, r_sr[StoreW-1:8]};
            end
        end else if (w_load_ch) begin
            r_sr <= {{ChW{1'b0}}, r_sr[StoreW-1:ChW]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load_ch || w_load_err) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_ch) begin
            o_channel_index    <= r_ch;
            o_raw_value        <= w_raw;
            o_scaled_value     <= w_scaled;
            o_changed          <= (w_raw != r_prev[0]);
            o_frame_error      <= 1'b0;
            o_failsafe         <= r_fs;
            o_frame_lost       <= r_lost;
            o_lost_frame_count <= w_lost_ext[OutCntW-1:0];
            o_error_count      <= w_err_ext[OutCntW-1:0];
            o_last             <= w_last_ch;
        end else if (w_load_err) begin
            o_channel_index    <= '0;
            o_raw_value        <= '0;
            o_scaled_value     <= '0;
            o_changed          <= 1'b0;
            o_frame_error      <= 1'b1;
            o_failsafe         <= 1'b0;
            o_frame_lost       <= 1'b0;
            o_lost_frame_count <= w_lost_ext[OutCntW-1:0];
            o_error_count      <= w_err_ext[OutCntW-1:0];
            o_last             <= 1'b1;
        end
    end

    `SBFD_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !o_out_valid, "reset must leave sequencer idle and output empty")
    `SBFD_ASSERT(a_pos_range, i_clk, i_rst_n, r_pos <= PosW'(StoreBytes), "byte position out of range")
    `SBFD_ASSERT(a_err_item, i_clk, i_rst_n, o_out_valid && o_frame_error |-> o_last && (o_raw_value == '0) && (o_channel_index == '0), "error item malformed")
    `SBFD_ASSERT(a_last_done, i_clk, i_rst_n, w_load_ch && w_last_ch |=> (r_state == S_IDLE) && o_last, "last channel did not end the sequence")
    `SBFD_ASSERT(a_ch_order, i_clk, i_rst_n, w_load_ch && !w_last_ch |=> (r_ch == $past(r_ch) + 1'b1) && (r_state == S_MUL), "channel sequence out of order")

endmodule
